// File: design/tcw_pkg.sv
// shared constants, codes and handshake structs of the text console writer
// no dependencies; imported by every module of the block except tcw_ram
`default_nettype none

package tcw_pkg;

    // screen geometry
    localparam int COLUMNS = 80;
    localparam int ROWS    = 25;
    localparam int CELLS   = COLUMNS * ROWS;

    localparam int ADDR_W  = $clog2(CELLS);      // ram address
    localparam int CUR_W   = $clog2(CELLS + 1);  // cursor may briefly sit one cell past the end
    localparam int COL_W   = $clog2(COLUMNS);
    localparam int ROW_W   = $clog2(ROWS + 1);
    localparam int WORD_W  = 16;
    localparam int IDX_W   = 11;                 // cell_index and cursor_pos ports
    localparam int OP_W    = 2;

    localparam logic [WORD_W-1:0] RESET_WORD = 16'h0F00;
    localparam logic [7:0]        RESET_ATTR = 8'h0F;

    // opcodes
    localparam logic [OP_W-1:0] OP_PUT   = 2'd0;
    localparam logic [OP_W-1:0] OP_READ  = 2'd1;
    localparam logic [OP_W-1:0] OP_CLEAR = 2'd2;

    // character codes
    localparam logic [7:0] CH_ESC   = 8'h1B;
    localparam logic [7:0] CH_BS    = 8'h08;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_SEMI  = 8'h3B;
    localparam logic [7:0] CH_LBRK  = 8'h5B;
    localparam logic [7:0] CH_M     = 8'h6D;

    // byte handed to the escape parser
    typedef struct packed {
        logic       put;
        logic [7:0] code;
    } esc_cmd_t;

    // escape parser state seen by the sequencer
    typedef struct packed {
        logic       in_escape;
        logic [7:0] attribute;
    } esc_stat_t;

    // control of the shared address walker
    typedef struct packed {
        logic              load;
        logic              step;
        logic [ADDR_W-1:0] start;
    } walk_ctl_t;

endpackage

`default_nettype wire

// File: design/text_console_writer_core.sv
// top level of the text console writer: sequencer, cursor and result register
// depends on tcw_pkg, tcw_ram, tcw_walker and tcw_escape
`default_nettype none

// An 80x25 text screen of 16-bit cells (attribute high, character low) held in one
// ram with a single write port, plus a cursor and an escape parser for colors.
// After reset the block sweeps every cell to 0x0F00, one per cycle, and takes no
// item during that sweep; configuration writes are taken at any time. A put that
// does not scroll goes straight to the result state, a read waits for the
// registered ram data, a clear sweeps every cell, and a scrolling put copies every
// row up one and then fills the last row; the input is ready again as the result
// goes valid. One shared address walker drives the ram a cell per cycle in every
// sweep. One item is in work at a time; the next may be taken while a result waits
// for transfer, and it stalls at its own result until the receiver takes the waiting one.
module text_console_writer_core
    import tcw_pkg::*;
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    // configuration
    input  wire logic             cfg_valid,
    output logic                  cfg_ready,
    input  wire logic             cfg_data,
    // items
    input  wire logic             in_valid,
    output logic                  in_ready,
    input  wire logic [OP_W-1:0]  opcode,
    input  wire logic [7:0]       char_code,
    input  wire logic [IDX_W-1:0] cell_index,
    // results
    output logic                  out_valid,
    input  wire logic             out_ready,
    output logic [IDX_W-1:0]      cursor_pos,
    output logic [WORD_W-1:0]     cell_word,
    output logic                  scrolled
);

    typedef enum logic [2:0] {
        S_INIT,
        S_IDLE,
        S_READ,
        S_CLEAR,
        S_COPY,
        S_DRAIN,
        S_FILL,
        S_DONE
    } state_t;

    state_t              state_reg, state_next;
    logic                escen_reg, escen_next;
    logic [CUR_W-1:0]    cursor_reg, cursor_next;
    logic [COL_W-1:0]    col_reg, col_next;
    logic [ROW_W-1:0]    row_reg, row_next;
    logic [WORD_W-1:0]   fill_reg, fill_next;
    logic [WORD_W-1:0]   word_reg, word_next;
    logic                scroll_reg, scroll_next;
    logic                oob_reg, oob_next;
    logic                pend_reg, pend_next;
    logic [ADDR_W-1:0]   pend_addr_reg, pend_addr_next;
    logic                out_valid_reg, out_valid_next;
    logic [IDX_W-1:0]    cursor_pos_reg, cursor_pos_next;
    logic [WORD_W-1:0]   cell_word_reg, cell_word_next;
    logic                scrolled_reg, scrolled_next;

    logic                accept;
    logic                plain;
    esc_cmd_t            esc_cmd;
    esc_stat_t           esc_stat;
    walk_ctl_t           walk_ctl;
    logic [ADDR_W-1:0]   walk_addr;
    logic                walk_last;

    logic                ram_we;
    logic [ADDR_W-1:0]   ram_waddr;
    logic [WORD_W-1:0]   ram_wdata;
    logic [ADDR_W-1:0]   ram_raddr;
    logic [WORD_W-1:0]   ram_rdata;

    // cursor move of a put byte outside an escape
    logic [CUR_W-1:0]    put_cur;
    logic [COL_W-1:0]    put_col;
    logic [ROW_W-1:0]    put_row;
    logic                put_we;
    logic [ADDR_W-1:0]   put_addr;
    logic [7:0]          put_char;
    logic                put_scroll;
    logic                advance;
    logic [2:0]          step;
    logic [COL_W:0]      col_sum;

    tcw_ram #(
        .WIDTH (WORD_W),
        .DEPTH (CELLS)
    ) u_screen (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    tcw_walker u_walker (
        .clk   (clk),
        .rst_n (rst_n),
        .ctl   (walk_ctl),
        .addr  (walk_addr),
        .last  (walk_last)
    );

    tcw_escape u_escape (
        .clk    (clk),
        .rst_n  (rst_n),
        .enable (escen_reg),
        .cmd    (esc_cmd),
        .stat   (esc_stat)
    );

    assign in_ready  = (state_reg == S_IDLE);
    assign cfg_ready = 1'b1;
    assign accept    = in_valid && in_ready;
    assign plain     = (opcode == OP_PUT) && (char_code != CH_ESC) && !esc_stat.in_escape;

    always_comb
    begin
        put_cur  = cursor_reg;
        put_col  = col_reg;
        put_row  = row_reg;
        put_we   = 1'b0;
        put_addr = ADDR_W'(cursor_reg);
        put_char = char_code;
        advance  = 1'b0;
        step     = 3'd1;
        case (char_code)
            CH_LF:
            begin
                put_cur = cursor_reg + (CUR_W'(COLUMNS) - CUR_W'(col_reg));
                put_col = '0;
                put_row = row_reg + ROW_W'(1);
            end
            CH_CR:
            begin
                put_cur = cursor_reg - CUR_W'(col_reg);
                put_col = '0;
            end
            CH_TAB:
            begin
                // distance to the next multiple of four
                advance = 1'b1;
                step    = 3'd4 - {1'b0, cursor_reg[1:0]};
            end
            CH_BS:
            begin
                put_we   = 1'b1;
                put_char = CH_SPACE;
                if (cursor_reg != '0)
                begin
                    put_cur = cursor_reg - CUR_W'(1);
                    if (col_reg == '0)
                    begin
                        put_col = COL_W'(COLUMNS - 1);
                        put_row = row_reg - ROW_W'(1);
                    end
                    else
                    begin
                        put_col = col_reg - COL_W'(1);
                    end
                end
                put_addr = ADDR_W'(put_cur);
            end
            default:
            begin
                if (char_code >= CH_SPACE)
                begin
                    put_we  = 1'b1;
                    advance = 1'b1;
                end
            end
        endcase

        col_sum = {1'b0, col_reg} + (COL_W + 1)'(step);
        if (advance)
        begin
            put_cur = cursor_reg + CUR_W'(step);
            if (col_sum >= (COL_W + 1)'(COLUMNS))
            begin
                put_col = COL_W'(col_sum - (COL_W + 1)'(COLUMNS));
                put_row = row_reg + ROW_W'(1);
            end
            else
            begin
                put_col = COL_W'(col_sum);
            end
        end

        put_scroll = (put_row == ROW_W'(ROWS));
        if (put_scroll)
        begin
            put_cur = put_cur - CUR_W'(COLUMNS);
            put_row = ROW_W'(ROWS - 1);
        end
    end

    always_comb
    begin
        state_next      = state_reg;
        escen_next      = escen_reg;
        cursor_next     = cursor_reg;
        col_next        = col_reg;
        row_next        = row_reg;
        fill_next       = fill_reg;
        word_next       = word_reg;
        scroll_next     = scroll_reg;
        oob_next        = oob_reg;
        pend_next       = pend_reg;
        pend_addr_next  = pend_addr_reg;
        out_valid_next  = out_valid_reg && !out_ready;
        cursor_pos_next = cursor_pos_reg;
        cell_word_next  = cell_word_reg;
        scrolled_next   = scrolled_reg;

        ram_we         = 1'b0;
        ram_waddr      = walk_addr;
        ram_wdata      = fill_reg;
        ram_raddr      = walk_addr;
        walk_ctl.load  = 1'b0;
        walk_ctl.step  = 1'b0;
        walk_ctl.start = '0;
        esc_cmd.put    = 1'b0;
        esc_cmd.code   = char_code;

        if (cfg_valid && cfg_ready)
        begin
            escen_next = cfg_data;
        end

        unique case (state_reg)
            S_INIT:
            begin
                ram_we        = 1'b1;
                ram_wdata     = RESET_WORD;
                walk_ctl.step = 1'b1;
                if (walk_last)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                ram_raddr = cell_index[ADDR_W-1:0];
                if (accept)
                begin
                    scroll_next = 1'b0;
                    word_next   = '0;
                    unique case (opcode)
                        OP_PUT:
                        begin
                            esc_cmd.put = 1'b1;
                            state_next  = S_DONE;
                            if (plain)
                            begin
                                ram_we      = put_we;
                                ram_waddr   = put_addr;
                                ram_wdata   = {esc_stat.attribute, put_char};
                                cursor_next = put_cur;
                                col_next    = put_col;
                                row_next    = put_row;
                                if (put_scroll)
                                begin
                                    scroll_next    = 1'b1;
                                    fill_next      = {esc_stat.attribute, CH_SPACE};
                                    walk_ctl.load  = 1'b1;
                                    walk_ctl.start = ADDR_W'(COLUMNS);
                                    state_next     = S_COPY;
                                end
                            end
                        end
                        OP_READ:
                        begin
                            oob_next   = (cell_index >= IDX_W'(CELLS));
                            state_next = S_READ;
                        end
                        OP_CLEAR:
                        begin
                            fill_next      = {esc_stat.attribute, 8'h00};
                            walk_ctl.load  = 1'b1;
                            walk_ctl.start = '0;
                            cursor_next    = '0;
                            col_next       = '0;
                            row_next       = '0;
                            state_next     = S_CLEAR;
                        end
                        default:
                        begin
                            state_next = S_DONE;
                        end
                    endcase
                end
            end
            S_READ:
            begin
                word_next  = oob_reg ? '0 : ram_rdata;
                state_next = S_DONE;
            end
            S_CLEAR:
            begin
                ram_we        = 1'b1;
                walk_ctl.step = 1'b1;
                if (walk_last)
                begin
                    state_next = S_DONE;
                end
            end
            S_COPY:
            begin
                // read one row below, write back the data read in the previous cycle
                ram_we         = pend_reg;
                ram_waddr      = pend_addr_reg;
                ram_wdata      = ram_rdata;
                pend_next      = 1'b1;
                pend_addr_next = walk_addr - ADDR_W'(COLUMNS);
                walk_ctl.step  = 1'b1;
                if (walk_last)
                begin
                    state_next = S_DRAIN;
                end
            end
            S_DRAIN:
            begin
                ram_we         = 1'b1;
                ram_waddr      = pend_addr_reg;
                ram_wdata      = ram_rdata;
                pend_next      = 1'b0;
                walk_ctl.load  = 1'b1;
                walk_ctl.start = ADDR_W'(CELLS - COLUMNS);
                state_next     = S_FILL;
            end
            S_FILL:
            begin
                ram_we        = 1'b1;
                walk_ctl.step = 1'b1;
                if (walk_last)
                begin
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next  = 1'b1;
                    cursor_pos_next = IDX_W'(cursor_reg);
                    cell_word_next  = word_reg;
                    scrolled_next   = scroll_reg;
                    state_next      = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_INIT;
            escen_reg      <= 1'b1;
            cursor_reg     <= '0;
            col_reg        <= '0;
            row_reg        <= '0;
            fill_reg       <= '0;
            word_reg       <= '0;
            scroll_reg     <= 1'b0;
            oob_reg        <= 1'b0;
            pend_reg       <= 1'b0;
            pend_addr_reg  <= '0;
            out_valid_reg  <= 1'b0;
            cursor_pos_reg <= '0;
            cell_word_reg  <= '0;
            scrolled_reg   <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            escen_reg      <= escen_next;
            cursor_reg     <= cursor_next;
            col_reg        <= col_next;
            row_reg        <= row_next;
            fill_reg       <= fill_next;
            word_reg       <= word_next;
            scroll_reg     <= scroll_next;
            oob_reg        <= oob_next;
            pend_reg       <= pend_next;
            pend_addr_reg  <= pend_addr_next;
            out_valid_reg  <= out_valid_next;
            cursor_pos_reg <= cursor_pos_next;
            cell_word_reg  <= cell_word_next;
            scrolled_reg   <= scrolled_next;
        end
    end

    assign out_valid  = out_valid_reg;
    assign cursor_pos = cursor_pos_reg;
    assign cell_word  = cell_word_reg;
    assign scrolled   = scrolled_reg;

    // one item at a time: after a transfer the block is not ready in the next cycle
    a_busy_after_transfer: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("input taken while previous item still in work");

    a_cursor_on_screen: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (cursor_pos < IDX_W'(CELLS)))
        else $error("reported cursor off screen");

    // a scroll always leaves the cursor on the last row
    a_scroll_last_row: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && scrolled |-> (cursor_pos >= IDX_W'(CELLS - COLUMNS)))
        else $error("scroll reported with cursor above last row");

endmodule

`default_nettype wire

// File: design/tcw_ram.sv
// generic single write port, single read port ram with registered read data
// no dependencies
`default_nettype none

module tcw_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 2000
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

// File: design/tcw_walker.sv
// shared address walker: one incrementer and end compare used by every screen sweep
// depends on tcw_pkg
`default_nettype none

module tcw_walker
    import tcw_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire walk_ctl_t         ctl,
    output logic      [ADDR_W-1:0] addr,
    output logic                   last
);

    logic [ADDR_W-1:0] addr_reg;
    logic [ADDR_W-1:0] addr_next;

    always_comb
    begin
        addr_next = addr_reg;
        if (ctl.load)
        begin
            addr_next = ctl.start;
        end
        else if (ctl.step)
        begin
            addr_next = addr_reg + ADDR_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            addr_reg <= '0;
        end
        else
        begin
            addr_reg <= addr_next;
        end
    end

    // every sweep ends at the last cell
    assign addr = addr_reg;
    assign last = (addr_reg == ADDR_W'(CELLS - 1));

endmodule

`default_nettype wire

// File: design/tcw_escape.sv
// escape sequence parser: attribute, saved attribute and octal color accumulators
// depends on tcw_pkg
`default_nettype none

module tcw_escape
    import tcw_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      enable,
    input  wire esc_cmd_t  cmd,
    output esc_stat_t      stat
);

    logic        in_escape_reg, in_escape_next;
    logic        bracket_reg, bracket_next;
    logic [7:0]  attr_reg, attr_next;
    logic [7:0]  saved_reg, saved_next;
    logic [15:0] acc_reg, acc_next;
    logic [15:0] bg_reg, bg_next;
    logic        is_digit;

    assign is_digit = (cmd.code >= CH_ZERO) && (cmd.code <= CH_NINE);

    always_comb
    begin
        in_escape_next = in_escape_reg;
        bracket_next   = bracket_reg;
        attr_next      = attr_reg;
        saved_next     = saved_reg;
        acc_next       = acc_reg;
        bg_next        = bg_reg;
        if (cmd.put)
        begin
            if (cmd.code == CH_ESC)
            begin
                in_escape_next = 1'b1;
            end
            else if (in_escape_reg)
            begin
                if (!enable)
                begin
                    if (cmd.code == CH_M)
                    begin
                        in_escape_next = 1'b0;
                    end
                end
                else if (cmd.code == CH_LBRK)
                begin
                    saved_next   = attr_reg;
                    bracket_next = 1'b1;
                end
                else if (is_digit)
                begin
                    // octal digit string, wraps at 16 bits
                    acc_next = {acc_reg[12:0], 3'b000} + {12'h000, cmd.code[3:0]};
                end
                else if (bracket_reg)
                begin
                    if (cmd.code == CH_SEMI)
                    begin
                        bg_next      = bg_reg + acc_reg;
                        acc_next     = '0;
                        bracket_next = 1'b0;
                    end
                    else if (cmd.code == CH_M)
                    begin
                        // no separator seen: restore the attribute
                        attr_next      = saved_reg;
                        acc_next       = '0;
                        bg_next        = '0;
                        bracket_next   = 1'b0;
                        in_escape_next = 1'b0;
                    end
                end
                else if (cmd.code == CH_M)
                begin
                    attr_next      = {bg_reg[3:0], 4'h0} | acc_reg[7:0];
                    acc_next       = '0;
                    bg_next        = '0;
                    bracket_next   = 1'b0;
                    in_escape_next = 1'b0;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_escape_reg <= 1'b0;
            bracket_reg   <= 1'b0;
            attr_reg      <= RESET_ATTR;
            saved_reg     <= '0;
            acc_reg       <= '0;
            bg_reg        <= '0;
        end
        else
        begin
            in_escape_reg <= in_escape_next;
            bracket_reg   <= bracket_next;
            attr_reg      <= attr_next;
            saved_reg     <= saved_next;
            acc_reg       <= acc_next;
            bg_reg        <= bg_next;
        end
    end

    assign stat.in_escape = in_escape_reg;
    assign stat.attribute = attr_reg;

endmodule

`default_nettype wire

// File: dv/text_console_writer_core_test.sv
// self-checking testbench for text_console_writer_core: directed table, then random traffic
// depends on tcw_pkg and the text_console_writer_core rtl
`default_nettype none

module text_console_writer_core_test
    import tcw_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
    localparam int              HEAVY_CAP = 250;         // cap on scrolls plus clears, each a sweep of the whole screen
    localparam int              TIMEOUT_NS = 12 * 5_000_000;

    typedef struct packed {
        logic [IDX_W-1:0]  pos;
        logic [WORD_W-1:0] word;
        logic              scr;
    } console_result_t;

    typedef struct {
        logic [OP_W-1:0]  op;
        logic [7:0]       ch;
        logic [IDX_W-1:0] idx;
        bit               typed;
        console_result_t  want;
    } directed_row_t;

    localparam console_result_t NO_WANT = '0;

    logic              clk = 1'b0;
    logic              rst_n;
    logic              cfg_valid;
    logic              cfg_ready;
    logic              cfg_data;
    logic              in_valid;
    logic              in_ready;
    logic [OP_W-1:0]   opcode;
    logic [7:0]        char_code;
    logic [IDX_W-1:0]  cell_index;
    logic              out_valid;
    logic              out_ready;
    logic [IDX_W-1:0]  cursor_pos;
    logic [WORD_W-1:0] cell_word;
    logic              scrolled;

    text_console_writer_core dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_data   (cfg_data),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .opcode     (opcode),
        .char_code  (char_code),
        .cell_index (cell_index),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .cursor_pos (cursor_pos),
        .cell_word  (cell_word),
        .scrolled   (scrolled)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // shadow of the screen, cursor and escape parser
    logic [WORD_W-1:0] screen_shadow [0:CELLS-1];
    int unsigned       cur_cell;
    logic [7:0]        attr;
    logic [7:0]        saved_attr;
    bit                in_esc;
    bit                brk_open;
    logic [15:0]       digit_acc;
    logic [15:0]       bg_acc;
    bit                colors_on;

    console_result_t console_results_due [$];

    int  items_sent;
    int  heavy_ops;
    int  n_scrolls;
    int  n_clears;
    int  n_reads;
    int  n_color_seqs;
    int  n_mode_writes;
    int  fail_count;
    bit  quiet;
    bit  hold;

    function automatic void shadow_reset();
        for (int i = 0; i < CELLS; i++)
            screen_shadow[i] = RESET_WORD;
        cur_cell   = 0;
        attr       = RESET_ATTR;
        saved_attr = 8'h00;
        in_esc     = 1'b0;
        brk_open   = 1'b0;
        digit_acc  = 16'h0;
        bg_acc     = 16'h0;
        colors_on  = 1'b1;
    endfunction

    function automatic void finish_sequence();
        digit_acc = 16'h0;
        bg_acc    = 16'h0;
        brk_open  = 1'b0;
        in_esc    = 1'b0;
    endfunction

    function automatic void escape_char(logic [7:0] ch);
        if (!colors_on)
        begin
            if (ch == CH_M)
                in_esc = 1'b0;
        end
        else if (ch == CH_LBRK)
        begin
            saved_attr = attr;
            brk_open   = 1'b1;
        end
        else if (ch >= CH_ZERO && ch <= CH_NINE)
            digit_acc = digit_acc * 16'd8 + {8'h00, ch - CH_ZERO};
        else if (brk_open)
        begin
            if (ch == CH_SEMI)
            begin
                bg_acc    = bg_acc + digit_acc;
                digit_acc = 16'h0;
                brk_open  = 1'b0;
            end
            else if (ch == CH_M)
            begin
                attr = saved_attr;
                finish_sequence();
            end
        end
        else if (ch == CH_M)
        begin
            attr = {bg_acc[3:0], 4'h0} | digit_acc[7:0];
            finish_sequence();
        end
    endfunction

    // returns 1 when the put scrolled the screen
    function automatic bit put_char(logic [7:0] ch);
        logic [WORD_W-1:0] blank;
        blank = {attr, CH_SPACE};
        if (ch == CH_ESC)
        begin
            in_esc = 1'b1;
            return 1'b0;
        end
        if (in_esc)
        begin
            escape_char(ch);
            return 1'b0;
        end
        if (ch == CH_LF)
            cur_cell = cur_cell + COLUMNS - cur_cell % COLUMNS;
        else if (ch == CH_BS)
        begin
            if (cur_cell > 0)
                cur_cell--;
            screen_shadow[cur_cell] = blank;
        end
        else if (ch == CH_TAB)
            cur_cell = (cur_cell + 4) & ~32'd3;
        else if (ch == CH_CR)
            cur_cell = (cur_cell / COLUMNS) * COLUMNS;
        else if (ch >= CH_SPACE)
        begin
            if (cur_cell < CELLS)
                screen_shadow[cur_cell] = {attr, ch};
            cur_cell++;
        end
        if (cur_cell / COLUMNS > ROWS - 1)
        begin
            for (int i = 0; i < CELLS - COLUMNS; i++)
                screen_shadow[i] = screen_shadow[i + COLUMNS];
            for (int i = CELLS - COLUMNS; i < CELLS; i++)
                screen_shadow[i] = blank;
            cur_cell = cur_cell - COLUMNS;
            return 1'b1;
        end
        return 1'b0;
    endfunction

    function automatic console_result_t console_step(logic [OP_W-1:0] op, logic [7:0] ch,
                                                     logic [IDX_W-1:0] idx);
        console_result_t r;
        r = '0;
        case (op)
            OP_PUT:
                r.scr = put_char(ch);
            OP_READ:
                if (idx < CELLS)
                    r.word = screen_shadow[idx];
            OP_CLEAR:
            begin
                for (int i = 0; i < CELLS; i++)
                    screen_shadow[i] = {attr, 8'h00};
                cur_cell = 0;
            end
            default:
                ;
        endcase
        r.pos = cur_cell[IDX_W-1:0];
        return r;
    endfunction

    task automatic offer_item(input logic [OP_W-1:0] op, input logic [7:0] ch,
                              input logic [IDX_W-1:0] idx, input bit typed,
                              input console_result_t typed_want);
        console_result_t want;
        while (!quiet && $urandom_range(0, 99) < 18)
        begin
            in_valid = 1'b0;
            @(negedge clk);
        end
        in_valid   = 1'b1;
        opcode     = op;
        char_code  = ch;
        cell_index = idx;
        do
            @(posedge clk);
        while (!in_ready);
        want = console_step(op, ch, idx);
        if (want.scr)
            n_scrolls++;
        if (want.scr || op == OP_CLEAR)
            heavy_ops++;
        if (op == OP_CLEAR)
            n_clears++;
        if (op == OP_READ)
            n_reads++;
        console_results_due.push_back(typed ? typed_want : want);
        items_sent++;
        @(negedge clk);
    endtask

    task automatic send_put(input logic [7:0] ch);
        offer_item(OP_PUT, ch, IDX_W'($urandom_range(0, 2047)), 1'b0, NO_WANT);
    endtask

    // mode register: only written once every result is back
    task automatic set_escape_colors(input bit on);
        in_valid = 1'b0;
        while (console_results_due.size() != 0)
            @(negedge clk);
        cfg_valid = 1'b1;
        cfg_data  = on;
        do
            @(posedge clk);
        while (!cfg_ready);
        colors_on = on;
        n_mode_writes++;
        @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    task automatic send_digits(input int count);
        for (int i = 0; i < count; i++)
            send_put(CH_ZERO + 8'($urandom_range(0, 9)));
    endtask

    // mostly well formed color sequences, some restores, some broken
    task automatic send_color_escape();
        int form;
        form = $urandom_range(0, 19);
        n_color_seqs++;
        if (form != 19)
            send_put(CH_ESC);
        if (form != 18)
            send_put(CH_LBRK);
        send_digits(form == 17 ? $urandom_range(3, 7) : $urandom_range(0, 2));
        if ($urandom_range(0, 7) == 0)
            send_put(8'($urandom_range(0, 255)));
        if (form < 12 || form >= 17)
        begin
            send_put(CH_SEMI);
            send_digits(form == 17 ? $urandom_range(3, 7) : $urandom_range(0, 2));
        end
        // an unterminated sequence is left hanging now and then
        if (form != 16 || $urandom_range(0, 3) != 0)
            send_put(CH_M);
    endtask

    task automatic random_item(input int nl_pct);
        int r;
        r = $urandom_range(0, 99);
        if (r < nl_pct)
            send_put(heavy_ops < HEAVY_CAP ? CH_LF : CH_CR);
        else
        begin
            r = $urandom_range(0, 99);
            if (r < 50)
                send_put(8'($urandom_range(32, 255)));
            else if (r < 62)
                offer_item(OP_READ, 8'($urandom_range(0, 255)),
                           ($urandom_range(0, 99) < 85) ? IDX_W'($urandom_range(0, CELLS - 1))
                                                        : IDX_W'($urandom_range(CELLS - 8, 2047)),
                           1'b0, NO_WANT);
            else if (r < 66)
                send_put(CH_CR);
            else if (r < 70)
                send_put(CH_TAB);
            else if (r < 75)
                send_put(CH_BS);
            else if (r < 78)
                send_put(8'($urandom_range(0, 31)));
            else if (r < 92)
                send_color_escape();
            else if (r < 94)
                offer_item(OP_UNUSED, 8'($urandom_range(0, 255)),
                           IDX_W'($urandom_range(0, 2047)), 1'b0, NO_WANT);
            else if (r < 95 && heavy_ops < HEAVY_CAP)
                offer_item(OP_CLEAR, 8'($urandom_range(0, 255)),
                           IDX_W'($urandom_range(0, 2047)), 1'b0, NO_WANT);
            else
                offer_item(OP_READ, 8'($urandom_range(0, 255)),
                           IDX_W'($urandom_range(0, 2047)), 1'b0, NO_WANT);
        end
    endtask

    task automatic check_result(input console_result_t got);
        console_result_t want;
        if (console_results_due.size() == 0)
        begin
            fail_count++;
            if (fail_count <= 10)
                $display("%0t: result with none awaited: cursor %0d word %h scrolled %0d",
                         $realtime, got.pos, got.word, got.scr);
            return;
        end
        want = console_results_due.pop_front();
        if (got.pos !== want.pos || got.word !== want.word || got.scr !== want.scr)
        begin
            fail_count++;
            if (fail_count <= 10)
                $display("%0t: mismatch cursor %0d/%0d word %h/%h scrolled %0d/%0d (exp/got)",
                         $realtime, want.pos, got.pos, want.word, got.word, want.scr, got.scr);
        end
    endtask

    // result side: sample at the rising edge
    initial
    begin
        forever
        begin
            @(posedge clk);
            if (rst_n === 1'b1 && out_valid === 1'b1 && out_ready)
                check_result('{cursor_pos, cell_word, scrolled});
        end
    end

    initial
    begin
        out_ready = 1'b0;
        forever
        begin
            @(negedge clk);
            out_ready = !hold && (quiet || $urandom_range(0, 99) >= 18);
        end
    end

    // long receiver hold-offs so the block backs up and stalls its input
    initial
    begin
        hold = 1'b0;
        wait (items_sent >= 400);
        @(posedge clk);
        hold = 1'b1;
        repeat (300) @(posedge clk);
        hold = 1'b0;
        wait (items_sent >= 1500);
        @(posedge clk);
        hold = 1'b1;
        repeat (250) @(posedge clk);
        hold = 1'b0;
    end

    initial
    begin
        #(TIMEOUT_NS);
        $display("*** FAILED ***");
        $finish;
    end

    directed_row_t directed_rows [0:24] = '{
        '{OP_READ,   8'h00,          11'd0,    1'b1, '{11'd0,  RESET_WORD, 1'b0}},
        '{OP_READ,   8'hFF,          11'd1999, 1'b1, '{11'd0,  RESET_WORD, 1'b0}},
        '{OP_READ,   8'h00,          11'h7FF,  1'b1, '{11'd0,  16'h0000,   1'b0}},
        '{OP_UNUSED, 8'hFF,          11'h7FF,  1'b1, '{11'd0,  16'h0000,   1'b0}},
        '{OP_PUT,    CH_BS,          11'd0,    1'b1, '{11'd0,  16'h0000,   1'b0}},
        '{OP_READ,   8'h00,          11'd0,    1'b1, '{11'd0,  {RESET_ATTR, CH_SPACE}, 1'b0}},
        '{OP_PUT,    8'h41,          11'h555,  1'b1, '{11'd1,  16'h0000,   1'b0}},
        '{OP_PUT,    8'hFF,          11'h2AA,  1'b1, '{11'd2,  16'h0000,   1'b0}},
        '{OP_PUT,    8'h00,          11'd0,    1'b1, '{11'd2,  16'h0000,   1'b0}},
        '{OP_PUT,    CH_TAB,         11'd0,    1'b1, '{11'd4,  16'h0000,   1'b0}},
        '{OP_PUT,    CH_CR,          11'd0,    1'b1, '{11'd0,  16'h0000,   1'b0}},
        '{OP_PUT,    CH_LF,          11'd0,    1'b1, '{11'd80, 16'h0000,   1'b0}},
        '{OP_PUT,    CH_ESC,         11'd0,    1'b1, '{11'd80, 16'h0000,   1'b0}},
        '{OP_PUT,    CH_LBRK,        11'd0,    1'b0, NO_WANT},
        '{OP_PUT,    CH_ZERO + 8'd1, 11'd0,    1'b0, NO_WANT},
        '{OP_PUT,    CH_SEMI,        11'd0,    1'b0, NO_WANT},
        '{OP_PUT,    CH_ZERO + 8'd7, 11'd0,    1'b0, NO_WANT},
        '{OP_PUT,    CH_NINE,        11'd0,    1'b0, NO_WANT},
        '{OP_PUT,    CH_M,           11'd0,    1'b0, NO_WANT},
        '{OP_PUT,    8'h42,          11'd0,    1'b0, NO_WANT},
        '{OP_READ,   8'h00,          11'd80,   1'b0, NO_WANT},
        '{OP_PUT,    CH_ESC,         11'd0,    1'b0, NO_WANT},
        '{OP_PUT,    CH_LBRK,        11'd0,    1'b0, NO_WANT},
        '{OP_PUT,    CH_M,           11'd0,    1'b0, NO_WANT},
        '{OP_CLEAR,  8'h00,          11'd0,    1'b1, '{11'd0,  16'h0000,   1'b0}}
    };

    int phase_len  [0:4] = '{500, 300, 550, 250, 225};
    bit phase_mode [0:4] = '{1'b1, 1'b0, 1'b1, 1'b0, 1'b1};

    initial
    begin
        int target;
        int run_left;
        int nl_pct;
        rst_n      = 1'b0;
        cfg_valid  = 1'b0;
        cfg_data   = 1'b0;
        in_valid   = 1'b0;
        opcode     = OP_PUT;
        char_code  = 8'h00;
        cell_index = '0;
        quiet      = 1'b0;
        items_sent = 0;
        heavy_ops  = 0;
        n_scrolls  = 0;
        n_clears   = 0;
        n_reads    = 0;
        n_color_seqs  = 0;
        n_mode_writes = 0;
        fail_count = 0;
        shadow_reset();
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        set_escape_colors(1'b1);
        foreach (directed_rows[i])
            offer_item(directed_rows[i].op, directed_rows[i].ch, directed_rows[i].idx,
                       directed_rows[i].typed, directed_rows[i].want);

        target = items_sent;
        for (int p = 0; p < 5; p++)
        begin
            set_escape_colors(phase_mode[p]);
            target += phase_len[p];
            while (items_sent < target)
            begin
                // episodes: plain text or newline runs (carriage returns once the heavy cap is reached)
                run_left = $urandom_range(10, 60);
                case ($urandom_range(0, 9))
                    0:       nl_pct = 3;
                    1, 2, 3: nl_pct = 35;
                    default: nl_pct = 3;
                endcase
                while (run_left > 0 && items_sent < target)
                begin
                    quiet = (items_sent >= 900 && items_sent < 1150);
                    random_item(nl_pct);
                    run_left--;
                end
            end
        end
        quiet    = 1'b0;
        in_valid = 1'b0;

        while (console_results_due.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);

        $display("ran %0d items: %0d reads, %0d scrolls, %0d clears, %0d color sequences",
                 items_sent, n_reads, n_scrolls, n_clears, n_color_seqs);
        $display("escape color mode written %0d times; %0d failures", n_mode_writes, fail_count);
        if (fail_count == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

`default_nettype wire

// File: text_console_writer_core.f
design/tcw_pkg.sv
design/tcw_ram.sv
design/tcw_walker.sv
design/tcw_escape.sv
design/text_console_writer_core.sv
dv/text_console_writer_core_test.sv
